// ===== rtl/core/sgrpd_pkg.sv =====
// sgrpd_pkg: types, codes and helpers for the sgr style parameter decoder
// used by sgrpd_step and sgr_style_parameter_decoder_core, no dependencies
`timescale 1ns / 1ps

package sgrpd_pkg;

	// longest sequence the count field can describe
	localparam int MAX_PARAMS = 32;
	localparam logic [4:0] AFTER_MAX = 5'(MAX_PARAMS - 1);

	// colour kinds
	localparam logic [1:0] KIND_DEFAULT = 2'd0;
	localparam logic [1:0] KIND_INDEXED = 2'd1;
	localparam logic [1:0] KIND_TRUE    = 2'd2;

	// attribute bit positions
	localparam int ATTR_BOLD      = 0;
	localparam int ATTR_DIM       = 1;
	localparam int ATTR_ITALIC    = 2;
	localparam int ATTR_UNDERLINE = 3;
	localparam int ATTR_INVERSE   = 4;
	localparam int ATTR_STRIKE    = 5;

	// sgr codes with special meaning
	localparam logic [14:0] SGR_RESET     = 15'd0;
	localparam logic [14:0] SGR_FG_EXT    = 15'd38;
	localparam logic [14:0] SGR_BG_EXT    = 15'd48;
	localparam logic signed [15:0] MODE_INDEXED = 16'sd5;
	localparam logic signed [15:0] MODE_TRUE    = 16'sd2;

	// extended colour sub-sequence phase
	typedef enum logic [2:0] {
		PH_NORMAL = 3'd0,
		PH_MODE   = 3'd1,
		PH_INDEX  = 3'd2,
		PH_RED    = 3'd3,
		PH_GREEN  = 3'd4,
		PH_BLUE   = 3'd5
	} phase_t;

	typedef struct packed {
		logic signed [15:0] param_value;
		logic [4:0]         params_after;
	} in_t;

	typedef struct packed {
		logic [1:0]  fore_kind;
		logic [23:0] fore_value;
		logic [1:0]  back_kind;
		logic [23:0] back_value;
		logic [5:0]  attr_mask;
		logic        sequence_end;
	} out_t;

	typedef struct packed {
		logic [1:0]  fg_kind;
		logic [23:0] fg_color;
		logic [1:0]  bg_kind;
		logic [23:0] bg_color;
		logic [5:0]  attr_bits;
	} style_t;

	typedef struct packed {
		phase_t     phase;
		logic       target_fg;
		logic [7:0] held_red;
		logic [7:0] held_green;
	} ext_t;

	// clamp a signed parameter to 0..255
	function automatic logic [7:0] sat_byte(input logic signed [15:0] v);
		logic [7:0] r;
		if (v[15]) begin
			r = 8'd0;
		end else if (v[14:8] != 7'd0) begin
			r = 8'd255;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/sgrpd_step.sv =====
// sgrpd_step: next style and extended-colour phase for one sgr parameter
// depends on sgrpd_pkg
`timescale 1ns / 1ps

module sgrpd_step (
	input  sgrpd_pkg::style_t style,
	input  sgrpd_pkg::ext_t   ext,
	input  sgrpd_pkg::in_t    item,
	output sgrpd_pkg::style_t style_next,
	output sgrpd_pkg::ext_t   ext_next
);

	logic [4:0]  after;
	logic [14:0] pz;
	logic [7:0]  pb;
	logic [7:0]  comp;

	assign after = (item.params_after > sgrpd_pkg::AFTER_MAX) ?
		sgrpd_pkg::AFTER_MAX : item.params_after;
	// negative counts as zero
	assign pz   = item.param_value[15] ? 15'd0 : item.param_value[14:0];
	assign pb   = pz[7:0];
	assign comp = sgrpd_pkg::sat_byte(item.param_value);

	always_comb begin
		style_next = style;
		ext_next   = ext;
		case (ext.phase)
			sgrpd_pkg::PH_MODE: begin
				if (item.param_value == sgrpd_pkg::MODE_INDEXED && after >= 5'd1) begin
					ext_next.phase = sgrpd_pkg::PH_INDEX;
				end else if (item.param_value == sgrpd_pkg::MODE_TRUE && after >= 5'd3) begin
					ext_next.phase = sgrpd_pkg::PH_RED;
				end else begin
					ext_next.phase = sgrpd_pkg::PH_NORMAL;
				end
			end
			sgrpd_pkg::PH_INDEX: begin
				if (ext.target_fg) begin
					style_next.fg_kind  = sgrpd_pkg::KIND_INDEXED;
					style_next.fg_color = {16'd0, comp};
				end else begin
					style_next.bg_kind  = sgrpd_pkg::KIND_INDEXED;
					style_next.bg_color = {16'd0, comp};
				end
				ext_next.phase = sgrpd_pkg::PH_NORMAL;
			end
			sgrpd_pkg::PH_RED: begin
				ext_next.held_red = comp;
				ext_next.phase    = sgrpd_pkg::PH_GREEN;
			end
			sgrpd_pkg::PH_GREEN: begin
				ext_next.held_green = comp;
				ext_next.phase      = sgrpd_pkg::PH_BLUE;
			end
			sgrpd_pkg::PH_BLUE: begin
				if (ext.target_fg) begin
					style_next.fg_kind  = sgrpd_pkg::KIND_TRUE;
					style_next.fg_color = {ext.held_red, ext.held_green, comp};
				end else begin
					style_next.bg_kind  = sgrpd_pkg::KIND_TRUE;
					style_next.bg_color = {ext.held_red, ext.held_green, comp};
				end
				ext_next.phase = sgrpd_pkg::PH_NORMAL;
			end
			default: begin
				// normal parameter, also the unreachable phase codes
				ext_next.phase = sgrpd_pkg::PH_NORMAL;
				case (pz) inside
					sgrpd_pkg::SGR_RESET: style_next = '0;
					15'd1:  style_next.attr_bits[sgrpd_pkg::ATTR_BOLD]      = 1'b1;
					15'd2:  style_next.attr_bits[sgrpd_pkg::ATTR_DIM]       = 1'b1;
					15'd3:  style_next.attr_bits[sgrpd_pkg::ATTR_ITALIC]    = 1'b1;
					15'd4:  style_next.attr_bits[sgrpd_pkg::ATTR_UNDERLINE] = 1'b1;
					15'd7:  style_next.attr_bits[sgrpd_pkg::ATTR_INVERSE]   = 1'b1;
					15'd9:  style_next.attr_bits[sgrpd_pkg::ATTR_STRIKE]    = 1'b1;
					15'd22: begin
						style_next.attr_bits[sgrpd_pkg::ATTR_BOLD] = 1'b0;
						style_next.attr_bits[sgrpd_pkg::ATTR_DIM]  = 1'b0;
					end
					15'd23: style_next.attr_bits[sgrpd_pkg::ATTR_ITALIC]    = 1'b0;
					15'd24: style_next.attr_bits[sgrpd_pkg::ATTR_UNDERLINE] = 1'b0;
					15'd27: style_next.attr_bits[sgrpd_pkg::ATTR_INVERSE]   = 1'b0;
					15'd29: style_next.attr_bits[sgrpd_pkg::ATTR_STRIKE]    = 1'b0;
					[15'd30:15'd37]: begin
						style_next.fg_kind  = sgrpd_pkg::KIND_INDEXED;
						style_next.fg_color = {16'd0, pb - 8'd30};
					end
					15'd39: begin
						style_next.fg_kind  = sgrpd_pkg::KIND_DEFAULT;
						style_next.fg_color = 24'd0;
					end
					[15'd40:15'd47]: begin
						style_next.bg_kind  = sgrpd_pkg::KIND_INDEXED;
						style_next.bg_color = {16'd0, pb - 8'd40};
					end
					15'd49: begin
						style_next.bg_kind  = sgrpd_pkg::KIND_DEFAULT;
						style_next.bg_color = 24'd0;
					end
					[15'd90:15'd97]: begin
						style_next.fg_kind  = sgrpd_pkg::KIND_INDEXED;
						style_next.fg_color = {16'd0, pb - 8'd82};
					end
					[15'd100:15'd107]: begin
						style_next.bg_kind  = sgrpd_pkg::KIND_INDEXED;
						style_next.bg_color = {16'd0, pb - 8'd92};
					end
					sgrpd_pkg::SGR_FG_EXT, sgrpd_pkg::SGR_BG_EXT: begin
						// start of a 38/48 sub-sequence needs a mode after it
						if (after != 5'd0) begin
							ext_next.target_fg = (pz == sgrpd_pkg::SGR_FG_EXT);
							ext_next.phase     = sgrpd_pkg::PH_MODE;
						end
					end
					default: ;
				endcase
			end
		endcase
		// last parameter of the sequence drops any pending sub-sequence
		if (after == 5'd0) begin
			ext_next.phase = sgrpd_pkg::PH_NORMAL;
		end
	end

endmodule

// ===== rtl/core/sgr_style_parameter_decoder_core.sv =====
// sgr style parameter decoder: input register, then result register, which loads only
// when empty or being drained; throughput one transaction per cycle while result_ready
// does not stall it; the input register feeds one decode step whose result updates the
// style state and the result register in the same edge
// arst_n clears the style, the extended-colour phase and both valid flags
// depends on sgrpd_pkg and sgrpd_step
`timescale 1ns / 1ps

module sgr_style_parameter_decoder_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sgrpd_pkg::in_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output sgrpd_pkg::out_t   result
);

	// input stage
	logic              valid_s1;
	sgrpd_pkg::in_t    item_s1;

	// running style and sub-sequence state
	sgrpd_pkg::style_t style_q;
	sgrpd_pkg::ext_t   ext_q;
	sgrpd_pkg::style_t style_next;
	sgrpd_pkg::ext_t   ext_next;

	// result register
	logic              out_valid_q;
	sgrpd_pkg::out_t   out_q;

	logic              advance;

	// the input stage moves on when the result register is empty or being drained
	assign advance    = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	sgrpd_step u_step (
		.style      (style_q),
		.ext        (ext_q),
		.item       (item_s1),
		.style_next (style_next),
		.ext_next   (ext_next)
	);

	// style state commits exactly once per parameter, when it leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q <= '0;
			ext_q   <= '{phase: sgrpd_pkg::PH_NORMAL, target_fg: 1'b0,
				held_red: 8'd0, held_green: 8'd0};
		end else if (advance) begin
			style_q <= style_next;
			ext_q   <= ext_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result transaction carries the style after this parameter
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.fore_kind    <= style_next.fg_kind;
			out_q.fore_value   <= style_next.fg_color;
			out_q.back_kind    <= style_next.bg_kind;
			out_q.back_value   <= style_next.bg_color;
			out_q.attr_mask    <= style_next.attr_bits;
			out_q.sequence_end <= (item_s1.params_after == 5'd0);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// sequence end always leaves the sub-sequence phase idle
	a_end_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.params_after == 5'd0 |=> ext_q.phase == sgrpd_pkg::PH_NORMAL)
		else $error("phase pending after last parameter");

	// default colours carry a zero value
	a_fore_default_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.fore_kind == sgrpd_pkg::KIND_DEFAULT |-> out_q.fore_value == 24'd0)
		else $error("default foreground with nonzero value");

	a_back_default_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.back_kind == sgrpd_pkg::KIND_DEFAULT |-> out_q.back_value == 24'd0)
		else $error("default background with nonzero value");

	// an empty result register never holds back the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> item_ready)
		else $error("input stalled with empty result register");

	// a result is valid in the cycle after the input stage advances
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("advanced parameter produced no result");

endmodule

// ===== tb/sgr_style_parameter_decoder_core_tb.sv =====
// sgr_style_parameter_decoder_core_tb: self-checking bench for the sgr style parameter decoder
// predicts every style result from the accepted parameters; depends on sgrpd_pkg and the core
`timescale 1ns / 1ps

module sgr_style_parameter_decoder_core_tb;

	// plain sgr codes the core decodes (reset and extended starts come from the package)
	localparam int SGR_BOLD             = 1;
	localparam int SGR_DIM              = 2;
	localparam int SGR_ITALIC           = 3;
	localparam int SGR_UNDERLINE        = 4;
	localparam int SGR_INVERSE          = 7;
	localparam int SGR_STRIKE           = 9;
	localparam int SGR_NORMAL_INTENSITY = 22;
	localparam int SGR_NO_ITALIC        = 23;
	localparam int SGR_NO_UNDERLINE     = 24;
	localparam int SGR_NO_INVERSE       = 27;
	localparam int SGR_NO_STRIKE        = 29;
	localparam int SGR_FG_BASE          = 30;
	localparam int SGR_FG_DEFAULT       = 39;
	localparam int SGR_BG_BASE          = 40;
	localparam int SGR_BG_DEFAULT       = 49;
	localparam int SGR_FG_BRIGHT        = 90;
	localparam int SGR_BG_BRIGHT        = 100;
	localparam int BANK_SIZE            = 8;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 40;

	logic            clk          = 1'b0;
	logic            arst_n       = 1'b0;
	logic            item_valid   = 1'b0;
	logic            item_ready;
	sgrpd_pkg::in_t  item         = '0;
	logic            result_valid;
	logic            result_ready = 1'b0;
	sgrpd_pkg::out_t result;

	sgr_style_parameter_decoder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// codes drawn for the plain part of random sequences
	int plain_codes [14] = '{sgrpd_pkg::SGR_RESET, SGR_BOLD, SGR_DIM, SGR_ITALIC,
		SGR_UNDERLINE, SGR_INVERSE, SGR_STRIKE, SGR_NORMAL_INTENSITY, SGR_NO_ITALIC,
		SGR_NO_UNDERLINE, SGR_NO_INVERSE, SGR_NO_STRIKE, SGR_FG_DEFAULT, SGR_BG_DEFAULT};

	// handshake mix of the current phase, in percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int errors          = 0;
	int params_sent     = 0;
	int sequences_sent  = 0;
	int indexed_applied = 0;
	int true_applied    = 0;
	int stall_cycles    = 0;

	// predicted style and extended-color progress
	sgrpd_pkg::style_t model_style = '0;
	sgrpd_pkg::ext_t   model_ext   = '0;

	sgrpd_pkg::out_t expected_styles [$];
	sgrpd_pkg::out_t want_style;
	logic signed [15:0] seq_buf [$];

	// -------------------------------------------------------------------------
	// style predictor
	// -------------------------------------------------------------------------

	// color components clamp to 0..255, negatives count as zero
	function automatic logic [7:0] clamp_component(input logic signed [15:0] v);
		logic [7:0] c;
		if (v < 0) begin
			c = 8'd0;
		end else if (v > 255) begin
			c = 8'd255;
		end else begin
			c = v[7:0];
		end
		return c;
	endfunction

	function automatic void paint(input logic [1:0] kind, input logic [23:0] value,
		input logic fore);
		if (fore) begin
			model_style.fg_kind  = kind;
			model_style.fg_color = value;
		end else begin
			model_style.bg_kind  = kind;
			model_style.bg_color = value;
		end
	endfunction

	// a parameter outside any extended-color sub-sequence
	function automatic void apply_plain(input logic signed [15:0] raw, input logic [4:0] after);
		int code;
		code = (raw < 0) ? 0 : int'(raw);
		if (code == sgrpd_pkg::SGR_RESET) begin
			model_style = '0;
		end else if (code == SGR_BOLD) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_BOLD] = 1'b1;
		end else if (code == SGR_DIM) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_DIM] = 1'b1;
		end else if (code == SGR_ITALIC) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_ITALIC] = 1'b1;
		end else if (code == SGR_UNDERLINE) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_UNDERLINE] = 1'b1;
		end else if (code == SGR_INVERSE) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_INVERSE] = 1'b1;
		end else if (code == SGR_STRIKE) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_STRIKE] = 1'b1;
		end else if (code == SGR_NORMAL_INTENSITY) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_BOLD] = 1'b0;
			model_style.attr_bits[sgrpd_pkg::ATTR_DIM]  = 1'b0;
		end else if (code == SGR_NO_ITALIC) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_ITALIC] = 1'b0;
		end else if (code == SGR_NO_UNDERLINE) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_UNDERLINE] = 1'b0;
		end else if (code == SGR_NO_INVERSE) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_INVERSE] = 1'b0;
		end else if (code == SGR_NO_STRIKE) begin
			model_style.attr_bits[sgrpd_pkg::ATTR_STRIKE] = 1'b0;
		end else if (code >= SGR_FG_BASE && code < SGR_FG_BASE + BANK_SIZE) begin
			paint(sgrpd_pkg::KIND_INDEXED, 24'(code - SGR_FG_BASE), 1'b1);
		end else if (code == SGR_FG_DEFAULT) begin
			paint(sgrpd_pkg::KIND_DEFAULT, 24'd0, 1'b1);
		end else if (code >= SGR_BG_BASE && code < SGR_BG_BASE + BANK_SIZE) begin
			paint(sgrpd_pkg::KIND_INDEXED, 24'(code - SGR_BG_BASE), 1'b0);
		end else if (code == SGR_BG_DEFAULT) begin
			paint(sgrpd_pkg::KIND_DEFAULT, 24'd0, 1'b0);
		end else if (code >= SGR_FG_BRIGHT && code < SGR_FG_BRIGHT + BANK_SIZE) begin
			paint(sgrpd_pkg::KIND_INDEXED, 24'(code - SGR_FG_BRIGHT + BANK_SIZE), 1'b1);
		end else if (code >= SGR_BG_BRIGHT && code < SGR_BG_BRIGHT + BANK_SIZE) begin
			paint(sgrpd_pkg::KIND_INDEXED, 24'(code - SGR_BG_BRIGHT + BANK_SIZE), 1'b0);
		end else if ((code == sgrpd_pkg::SGR_FG_EXT || code == sgrpd_pkg::SGR_BG_EXT)
			&& after != 5'd0) begin
			// extended color only starts when a mode can still follow
			model_ext.target_fg = (code == sgrpd_pkg::SGR_FG_EXT);
			model_ext.phase     = sgrpd_pkg::PH_MODE;
		end
	endfunction

	// advance the predicted state by one parameter and return the style it leaves
	function automatic sgrpd_pkg::out_t predict_style(input sgrpd_pkg::in_t txn);
		sgrpd_pkg::out_t    r;
		logic signed [15:0] p;
		logic [4:0]         after;
		logic               fore;
		p     = txn.param_value;
		after = txn.params_after;
		fore  = model_ext.target_fg;
		case (model_ext.phase)
			sgrpd_pkg::PH_MODE: begin
				// the mode is compared raw and needs enough parameters behind it
				if (p == sgrpd_pkg::MODE_INDEXED && after >= 5'd1) begin
					model_ext.phase = sgrpd_pkg::PH_INDEX;
				end else if (p == sgrpd_pkg::MODE_TRUE && after >= 5'd3) begin
					model_ext.phase = sgrpd_pkg::PH_RED;
				end else begin
					model_ext.phase = sgrpd_pkg::PH_NORMAL;
				end
			end
			sgrpd_pkg::PH_INDEX: begin
				paint(sgrpd_pkg::KIND_INDEXED, {16'd0, clamp_component(p)}, fore);
				model_ext.phase = sgrpd_pkg::PH_NORMAL;
				indexed_applied++;
			end
			sgrpd_pkg::PH_RED: begin
				model_ext.held_red = clamp_component(p);
				model_ext.phase    = sgrpd_pkg::PH_GREEN;
			end
			sgrpd_pkg::PH_GREEN: begin
				model_ext.held_green = clamp_component(p);
				model_ext.phase      = sgrpd_pkg::PH_BLUE;
			end
			sgrpd_pkg::PH_BLUE: begin
				paint(sgrpd_pkg::KIND_TRUE, {model_ext.held_red, model_ext.held_green,
					clamp_component(p)}, fore);
				model_ext.phase = sgrpd_pkg::PH_NORMAL;
				true_applied++;
			end
			default: begin
				model_ext.phase = sgrpd_pkg::PH_NORMAL;
				apply_plain(p, after);
			end
		endcase
		// the last parameter of a sequence abandons any unfinished color
		if (after == 5'd0) begin
			model_ext.phase = sgrpd_pkg::PH_NORMAL;
		end
		r.fore_kind    = model_style.fg_kind;
		r.fore_value   = model_style.fg_color;
		r.back_kind    = model_style.bg_kind;
		r.back_value   = model_style.bg_color;
		r.attr_mask    = model_style.attr_bits;
		r.sequence_end = (after == 5'd0);
		return r;
	endfunction

	// -------------------------------------------------------------------------
	// parameter driver
	// -------------------------------------------------------------------------

	// one parameter transaction; the prediction is taken at the accepting edge
	task automatic send_param(input logic signed [15:0] value, input logic [4:0] after);
		sgrpd_pkg::in_t txn;
		txn.param_value  = value;
		txn.params_after = after;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= txn;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		expected_styles.insert(expected_styles.size(), predict_style(txn));
		params_sent++;
	endtask

	// send seq_buf with matching counts, or now and then a wrong count when skewed
	task automatic send_sequence(input bit skew_counts);
		int         n;
		logic [4:0] after;
		n = seq_buf.size();
		for (int i = 0; i < n; i++) begin
			after = 5'(n - 1 - i);
			if (skew_counts && $urandom_range(3) == 0) begin
				after = 5'($urandom_range(31));
			end
			send_param(seq_buf[i], after);
		end
		sequences_sent++;
	endtask

	// the sender holds off until every predicted style has come back
	task automatic pause_until_drained();
		item_valid <= 1'b0;
		while (expected_styles.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// -------------------------------------------------------------------------
	// random sequence content
	// -------------------------------------------------------------------------

	// add one parameter at the end of seq_buf
	function automatic void append_param(input logic signed [15:0] v);
		seq_buf.insert(seq_buf.size(), v);
	endfunction

	function automatic logic [15:0] plain_code();
		logic [15:0] c;
		case ($urandom_range(5))
			0, 1:    c = 16'(plain_codes[$urandom_range(13)]);
			2:       c = 16'(SGR_FG_BASE + $urandom_range(BANK_SIZE - 1));
			3:       c = 16'(SGR_BG_BASE + $urandom_range(BANK_SIZE - 1));
			4:       c = 16'(SGR_FG_BRIGHT + $urandom_range(BANK_SIZE - 1));
			default: c = 16'(SGR_BG_BRIGHT + $urandom_range(BANK_SIZE - 1));
		endcase
		return c;
	endfunction

	// mostly in range, with the saturation edges and negatives mixed in
	function automatic logic [15:0] color_component();
		int          pick;
		logic [15:0] c;
		pick = $urandom_range(99);
		if (pick < 70) begin
			c = 16'($urandom_range(255));
		end else if (pick < 80) begin
			c = $urandom_range(1) ? 16'd255 : 16'd0;
		end else if (pick < 90) begin
			c = {1'b1, 15'($urandom)};
		end else begin
			c = 16'($urandom_range(32767, 256));
		end
		return c;
	endfunction

	// fill seq_buf with one sequence: plain codes, well-formed extended colors,
	// broken extended starts and raw noise
	task automatic build_random_sequence(input bit make_long);
		int          target;
		int          pick;
		logic [15:0] ext_code;
		seq_buf.delete();
		if (make_long) begin
			target = sgrpd_pkg::MAX_PARAMS;
		end else if ($urandom_range(14) == 0) begin
			target = $urandom_range(sgrpd_pkg::MAX_PARAMS, 17);
		end else begin
			target = $urandom_range(8, 1);
		end
		while (seq_buf.size() < target) begin
			pick     = $urandom_range(99);
			ext_code = $urandom_range(1) ? 16'(sgrpd_pkg::SGR_FG_EXT) :
				16'(sgrpd_pkg::SGR_BG_EXT);
			if (pick < 35) begin
				append_param(plain_code());
			end else if (pick < 55) begin
				append_param(ext_code);
				append_param(sgrpd_pkg::MODE_INDEXED);
				append_param(color_component());
			end else if (pick < 75) begin
				append_param(ext_code);
				append_param(sgrpd_pkg::MODE_TRUE);
				append_param(color_component());
				append_param(color_component());
				append_param(color_component());
			end else if (pick < 85) begin
				// extended start with an arbitrary small mode
				append_param(ext_code);
				append_param(16'($urandom_range(7)));
			end else begin
				append_param(16'($urandom));
			end
		end
		// the count field cannot describe more than this
		while (seq_buf.size() > sgrpd_pkg::MAX_PARAMS) begin
			void'(seq_buf.pop_back());
		end
	endtask

	// -------------------------------------------------------------------------
	// tests
	// -------------------------------------------------------------------------

	// attribute set and clear, plain and bright palette selection
	task automatic test_attributes();
		seq_buf = '{16'(SGR_BOLD), 16'(SGR_DIM), 16'(SGR_UNDERLINE),
			16'(SGR_NORMAL_INTENSITY), 16'(SGR_FG_BASE + 1), 16'(SGR_BG_BRIGHT + 7)};
		send_sequence(1'b0);
	endtask

	// 256-color and true color, component saturation, a start with nothing after it
	task automatic test_extended_colors();
		seq_buf = '{16'(sgrpd_pkg::SGR_BG_EXT), sgrpd_pkg::MODE_TRUE, 16'sd300, -16'sd1,
			16'sd128, 16'(sgrpd_pkg::SGR_FG_EXT)};
		send_sequence(1'b0);
		// largest index saturates, then a true color mode too short to run
		seq_buf = '{16'(sgrpd_pkg::SGR_FG_EXT), sgrpd_pkg::MODE_INDEXED, 16'sh7fff,
			16'(sgrpd_pkg::SGR_BG_EXT), sgrpd_pkg::MODE_TRUE, 16'(SGR_INVERSE)};
		send_sequence(1'b0);
	endtask

	// index mode at the end, most negative reset, counts that cut a color short
	task automatic test_broken_extended();
		send_param(16'(sgrpd_pkg::SGR_FG_EXT), 5'd1);
		send_param(sgrpd_pkg::MODE_INDEXED, 5'd0);
		send_param(16'sh8000, 5'd0);
		send_param(16'(sgrpd_pkg::SGR_BG_EXT), 5'd5);
		send_param(sgrpd_pkg::MODE_TRUE, 5'd4);
		send_param(16'sd10, 5'd3);
		send_param(16'sd20, 5'd0);
		// empty sequence
		send_param(16'(sgrpd_pkg::SGR_RESET), 5'd0);
	endtask

	task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
		int stop_at;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at        = params_sent + count;
		// a full-length sequence first so every bit of the count is exercised
		build_random_sequence(1'b1);
		send_sequence(1'b0);
		while (params_sent < stop_at) begin
			build_random_sequence(1'b0);
			send_sequence($urandom_range(9) == 0);
		end
	endtask

	// -------------------------------------------------------------------------
	// result side
	// -------------------------------------------------------------------------

	// receiver back-pressure follows the phase's stall rate
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic check_field(input string name, input logic [23:0] want,
		input logic [23:0] got);
		if (want !== got) begin
			if (errors < MAX_REPORTS) begin
				$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
			end
			errors++;
		end
	endtask

	// each result transaction is held against the oldest predicted style
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_styles.size() == 0) begin
				if (errors < MAX_REPORTS) begin
					$display("%0t ns: result expected none actual %h", $time, result);
				end
				errors++;
			end else begin
				want_style = expected_styles[0];
				expected_styles.delete(0);
				check_field("fore_kind", 24'(want_style.fore_kind), 24'(result.fore_kind));
				check_field("fore_value", want_style.fore_value, result.fore_value);
				check_field("back_kind", 24'(want_style.back_kind), 24'(result.back_kind));
				check_field("back_value", want_style.back_value, result.back_value);
				check_field("attr_mask", 24'(want_style.attr_mask), 24'(result.attr_mask));
				check_field("sequence_end", 24'(want_style.sequence_end),
					24'(result.sequence_end));
			end
		end
	end

	// watchdog: too long without any transaction on either channel ends the run
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("sgr_style_parameter_decoder_core: mismatch");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// test sequence
	// -------------------------------------------------------------------------

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_attributes();
		test_extended_colors();
		test_broken_extended();

		test_random_traffic(300, 0, 0);
		pause_until_drained();
		test_random_traffic(280, 57, 0);
		test_random_traffic(280, 0, 57);
		pause_until_drained();
		test_random_traffic(270, 15, 15);

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d parameters in %0d sequences over four handshake mixes",
			params_sent, sequences_sent);
		$display("extended colors applied: %0d indexed, %0d true color",
			indexed_applied, true_applied);
		if (errors == 0) begin
			$display("sgr_style_parameter_decoder_core: match");
		end else begin
			$display("sgr_style_parameter_decoder_core: mismatch");
		end
		$finish;
	end

endmodule
